// ----- design/ltok_pkg.sv -----
// Shared types, constants and helpers for the line tokenizer.
package ltok_pkg;

    localparam int LINE_MAX = 256;
    localparam int POS_W    = $clog2(LINE_MAX + 1);
    localparam int CHAR_W   = 8;
    localparam int START_W  = 8;
    localparam int LEN_W    = 9;
    localparam int QDEPTH   = 3;
    localparam int CNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

    typedef enum logic [1:0] {
        MODE_GAP,
        MODE_IDENT,
        MODE_STRING,
        MODE_COMMENT
    } mode_t;

    typedef enum logic [1:0] {
        TYPE_IDENT,
        TYPE_STRING,
        TYPE_PUNCT,
        TYPE_END
    } tok_type_t;

    typedef struct packed {
        tok_type_t           kind;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        logic                last;
    } token_t;

    typedef struct packed {
        logic [1:0] n;
        token_t     r0;
        token_t     r1;
    } push_t;

    function automatic logic is_ident_char(input logic [CHAR_W-1:0] c);
        logic r;
        r = ((c >= 8'h61) && (c <= 8'h7A)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h30) && (c <= 8'h39)) ||
            (c == CH_DOLLAR) || (c == CH_UNDER);
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = (v == {LEN_W{1'b1}}) ? v : v + LEN_W'(1);
        return r;
    endfunction

endpackage

// ----- design/ltok_lexer.sv -----
// Lexer state, comment register and per-character token decode.
module ltok_lexer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [ltok_pkg::CHAR_W-1:0] char_in,
    input  logic                        cfg_wr_en,
    input  logic [ltok_pkg::CHAR_W-1:0] cfg_wr_data,
    output ltok_pkg::push_t             push
);
    import ltok_pkg::*;

    logic [CHAR_W-1:0]  comment_reg;
    mode_t              mode_reg, mode_next;
    logic [CHAR_W-1:0]  quote_reg, quote_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]   run_reg, run_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic gap_comment, gap_skip, gap_quote, gap_ident;
    logic [LEN_W-1:0] run_inc;
    token_t tok_cur, tok_end, tok_punct;

    always_comb
    begin
        gap_comment = (comment_reg != CH_NUL) && (char_in == comment_reg);
        gap_skip    = (char_in == CH_SPACE) || (char_in == CH_TAB);
        gap_quote   = (char_in == CH_DQUOTE) || (char_in == CH_SQUOTE);
        gap_ident   = is_ident_char(char_in);
        run_inc     = sat_inc(run_reg);

        tok_cur   = '{kind: TYPE_IDENT, start: start_reg, length: run_reg, last: 1'b0};
        tok_end   = '{kind: TYPE_END, start: pos_reg[START_W-1:0], length: '0, last: 1'b1};
        tok_punct = '{kind: TYPE_PUNCT, start: pos_reg[START_W-1:0],
                      length: LEN_W'(1), last: 1'b0};

        mode_next  = mode_reg;
        quote_next = quote_reg;
        start_next = start_reg;
        run_next   = run_reg;
        pos_next   = pos_reg;
        push       = '0;

        if (char_in == CH_NUL)
        begin
            if (mode_reg == MODE_IDENT || mode_reg == MODE_STRING)
            begin
                push.n       = 2'd2;
                push.r0      = tok_cur;
                push.r0.kind = (mode_reg == MODE_STRING) ? TYPE_STRING : TYPE_IDENT;
                push.r1      = tok_end;
            end
            else
            begin
                push.n  = 2'd1;
                push.r0 = tok_end;
            end
            mode_next  = MODE_GAP;
            quote_next = '0;
            start_next = '0;
            run_next   = '0;
            pos_next   = '0;
        end
        else if (pos_reg < POS_W'(LINE_MAX))
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                end
                MODE_STRING:
                begin
                    run_next = run_inc;
                    if (char_in == quote_reg)
                    begin
                        push.n         = 2'd1;
                        push.r0        = tok_cur;
                        push.r0.kind   = TYPE_STRING;
                        push.r0.length = run_inc;
                        mode_next      = MODE_GAP;
                        quote_next     = '0;
                        start_next     = '0;
                        run_next       = '0;
                    end
                end
                MODE_IDENT, MODE_GAP:
                begin
                    if (mode_reg == MODE_IDENT && gap_ident)
                    begin
                        run_next = run_inc;
                    end
                    else
                    begin
                        if (mode_reg == MODE_IDENT)
                        begin
                            push.n  = 2'd1;
                            push.r0 = tok_cur;
                        end
                        mode_next  = MODE_GAP;
                        quote_next = '0;
                        start_next = '0;
                        run_next   = '0;
                        priority if (gap_comment)
                        begin
                            mode_next = MODE_COMMENT;
                        end
                        else if (gap_skip)
                        begin
                        end
                        else if (gap_quote)
                        begin
                            mode_next  = MODE_STRING;
                            quote_next = char_in;
                            start_next = pos_reg[START_W-1:0];
                            run_next   = LEN_W'(1);
                        end
                        else if (gap_ident)
                        begin
                            mode_next  = MODE_IDENT;
                            start_next = pos_reg[START_W-1:0];
                            run_next   = LEN_W'(1);
                        end
                        else
                        begin
                            if (mode_reg == MODE_IDENT)
                            begin
                                push.n  = 2'd2;
                                push.r1 = tok_punct;
                            end
                            else
                            begin
                                push.n  = 2'd1;
                                push.r0 = tok_punct;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            push.r0.last = (push.n == 2'd1);
            push.r1.last = 1'b1;
        end

        if (!take)
        begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_reg <= '0;
            mode_reg    <= MODE_GAP;
            quote_reg   <= '0;
            start_reg   <= '0;
            run_reg     <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                comment_reg <= cfg_wr_data;
            end
            if (take)
            begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                start_reg <= start_next;
                run_reg   <= run_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

// ----- design/ltok_result_queue.sv -----
// Result register queue: takes up to two tokens per cycle, sends one.
module ltok_result_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  ltok_pkg::push_t  push,
    input  logic             pop,
    output logic             has_room,
    output logic             not_empty,
    output ltok_pkg::token_t head
);
    import ltok_pkg::*;

    token_t q_reg [QDEPTH];
    token_t q_next [QDEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base;
    logic [CNT_W:0]   base1;

    assign has_room  = (count_reg < CNT_W'(2));
    assign not_empty = (count_reg != '0);
    assign head      = q_reg[0];

    always_comb
    begin
        base  = count_reg - CNT_W'(pop);
        base1 = {1'b0, base} + (CNT_W + 1)'(1);
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && i < QDEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push.n != 2'd0 && CNT_W'(i) == base)
            begin
                q_next[i] = push.r0;
            end
            if (push.n == 2'd2 && (CNT_W + 1)'(i) == base1)
            begin
                q_next[i] = push.r1;
            end
        end
        count_next = base + CNT_W'(push.n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ----- design/line_tokenizer.sv -----
// Line tokenizer top level: lexer feeding a three-entry result queue.
// The lexer decodes each taken character combinationally; its tokens are registered in the result queue.
// Throughput: one character per cycle while at most one token waits in the queue;
// a character that closes an identifier and adds punctuation or end pushes two tokens.
// Input stalls while two or more tokens wait in the result queue.
// Reset clears lexer mode, offsets, comment character and the queue.
module line_tokenizer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ltok_pkg::CHAR_W-1:0]  char_in,
    input  logic                         cfg_wr_en,
    input  logic [ltok_pkg::CHAR_W-1:0]  cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   token_type,
    output logic [ltok_pkg::START_W-1:0] token_start,
    output logic [ltok_pkg::LEN_W-1:0]   token_length,
    output logic                         last
);
    import ltok_pkg::*;

    push_t  push;
    token_t head;
    logic   has_room;
    logic   take;

    assign in_stall = !has_room;
    assign take     = in_valid && has_room;

    ltok_lexer u_lexer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_in     (char_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    ltok_result_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_valid && !out_stall),
        .has_room  (has_room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign token_type   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last         = head.last;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_type == TYPE_END) |-> last)
        else $error("end token without last");

    a_end_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_type == TYPE_END) |-> (token_length == '0))
        else $error("end token with nonzero length");

    a_tok_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_type != TYPE_END) |-> (token_length != '0))
        else $error("empty token");

    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty queue");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the line tokenizer: random command lines, scoreboard, watchdog.
`timescale 1ns / 1ps

module testbench;
    import ltok_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 250;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [CHAR_W-1:0]   char_in      = '0;
    logic                cfg_wr_en    = 1'b0;
    logic [CHAR_W-1:0]   cfg_wr_data  = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [1:0]          token_type;
    logic [START_W-1:0]  token_start;
    logic [LEN_W-1:0]    token_length;
    logic                last;

    line_tokenizer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_type   (token_type),
        .token_start  (token_start),
        .token_length (token_length),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [CHAR_W-1:0] pending_chars [$];
    token_t            tokens_due [$];
    token_t            fresh_toks [$];
    int                send_idle   = 0;
    int                recv_idle   = 0;
    int                fail_count  = 0;
    int                quiet       = 0;
    logic [CHAR_W-1:0] cmt_setting = '0;

    // lexer shadow state
    mode_t             lx_mode    = MODE_GAP;
    logic [CHAR_W-1:0] lx_quote   = '0;
    logic [START_W-1:0] lx_start  = '0;
    logic [LEN_W-1:0]  lx_len     = '0;
    int                lx_pos     = 0;
    logic [CHAR_W-1:0] comment_ch = '0;

    function automatic logic word_char(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_DOLLAR || c == CH_UNDER;
    endfunction

    task automatic emit(input tok_type_t k, input logic [START_W-1:0] s,
                        input logic [LEN_W-1:0] n);
        token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = n;
        t.last   = 1'b0;
        fresh_toks.push_back(t);
    endtask

    task automatic lex_clear();
        lx_mode  = MODE_GAP;
        lx_quote = '0;
        lx_start = '0;
        lx_len   = '0;
    endtask

    task automatic lex_gap(input logic [CHAR_W-1:0] c);
        if (comment_ch != CH_NUL && c == comment_ch)
            lx_mode = MODE_COMMENT;
        else if (c == CH_SPACE || c == CH_TAB)
        begin
        end
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            lx_mode  = MODE_STRING;
            lx_quote = c;
            lx_start = START_W'(lx_pos);
            lx_len   = LEN_W'(1);
        end
        else if (word_char(c))
        begin
            lx_mode  = MODE_IDENT;
            lx_start = START_W'(lx_pos);
            lx_len   = LEN_W'(1);
        end
        else
            emit(TYPE_PUNCT, START_W'(lx_pos), LEN_W'(1));
    endtask

    task automatic lex_char(input logic [CHAR_W-1:0] c);
        token_t t;
        fresh_toks.delete();
        if (c == CH_NUL)
        begin
            if (lx_mode == MODE_IDENT)
                emit(TYPE_IDENT, lx_start, lx_len);
            else if (lx_mode == MODE_STRING)
                emit(TYPE_STRING, lx_start, lx_len);
            emit(TYPE_END, START_W'(lx_pos), '0);
            lex_clear();
            lx_pos = 0;
        end
        else if (lx_pos < LINE_MAX)
        begin
            case (lx_mode)
                MODE_COMMENT:
                begin
                end
                MODE_STRING:
                begin
                    if (lx_len != {LEN_W{1'b1}})
                        lx_len = lx_len + LEN_W'(1);
                    if (c == lx_quote)
                    begin
                        emit(TYPE_STRING, lx_start, lx_len);
                        lex_clear();
                    end
                end
                MODE_IDENT:
                begin
                    if (word_char(c))
                    begin
                        if (lx_len != {LEN_W{1'b1}})
                            lx_len = lx_len + LEN_W'(1);
                    end
                    else
                    begin
                        emit(TYPE_IDENT, lx_start, lx_len);
                        lex_clear();
                        lex_gap(c);
                    end
                end
                default:
                    lex_gap(c);
            endcase
            lx_pos++;
        end
        if (fresh_toks.size() > 0)
        begin
            t = fresh_toks.pop_back();
            t.last = 1'b1;
            fresh_toks.push_back(t);
            foreach (fresh_toks[i])
                tokens_due.push_back(fresh_toks[i]);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_valid <= 1'b1;
                char_in  <= pending_chars.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                char_in  <= CHAR_W'($urandom);
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // monitor and scoreboard
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                comment_ch = cfg_wr_data;
            if (in_valid && !in_stall)
                lex_char(char_in);
            if (out_valid && !out_stall)
            begin
                if (tokens_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected token: type %0d start %0d len %0d last %0d",
                                 token_type, token_start, token_length, last);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (token_type !== want.kind || token_start !== want.start ||
                        token_length !== want.length || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"token mismatch: exp type %0d start %0d len %0d last %0d,",
                                      " got type %0d start %0d len %0d last %0d"},
                                     want.kind, want.start, want.length, want.last,
                                     token_type, token_start, token_length, last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [CHAR_W-1:0] word_pick();
        int r;
        r = $urandom_range(63);
        if (r < 26)
            return CHAR_W'("a" + r);
        if (r < 52)
            return CHAR_W'("A" + r - 26);
        if (r < 62)
            return CHAR_W'("0" + r - 52);
        return (r == 62) ? CH_DOLLAR : CH_UNDER;
    endfunction

    function automatic logic [CHAR_W-1:0] punct_pick();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(255, 1));
        while (word_char(c) || c == CH_SPACE || c == CH_TAB ||
               c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] str_pick(input logic [CHAR_W-1:0] q);
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(255, 1));
        while (c == q);
        return c;
    endfunction

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(s[i]);
    endtask

    // one command line: mostly token streams, some noise, a few overlong lines
    task automatic queue_line(output int n);
        int pick;
        int ntok;
        int before_n;
        logic [CHAR_W-1:0] q;
        before_n = pending_chars.size();
        pick = $urandom_range(99);
        if (pick < 3)
            repeat ($urandom_range(320, 250))
                pending_chars.push_back(CHAR_W'($urandom_range(255, 1)));
        else if (pick < 13)
            repeat ($urandom_range(40, 1))
                pending_chars.push_back(CHAR_W'($urandom_range(255, 1)));
        else
        begin
            ntok = $urandom_range(8, 1);
            for (int k = 0; k < ntok; k++)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                        repeat ($urandom_range(8, 1))
                            pending_chars.push_back(word_pick());
                    3, 4:
                    begin
                        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                        pending_chars.push_back(q);
                        repeat ($urandom_range(6))
                            pending_chars.push_back(str_pick(q));
                        if ($urandom_range(7) != 0)
                            pending_chars.push_back(q);
                    end
                    5, 6:
                        pending_chars.push_back(punct_pick());
                    7:
                    begin
                        pending_chars.push_back(cmt_setting != CH_NUL ? cmt_setting
                                                                       : punct_pick());
                        repeat ($urandom_range(4))
                            pending_chars.push_back(word_pick());
                    end
                    default:
                        pending_chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                endcase
                if ($urandom_range(2) == 0)
                    pending_chars.push_back($urandom_range(3) == 0 ? CH_TAB : CH_SPACE);
            end
        end
        pending_chars.push_back(CH_NUL);
        n = pending_chars.size() - before_n;
    endtask

    task automatic set_comment(input logic [CHAR_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cmt_setting = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || in_valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int added;
        int n;
        logic [CHAR_W-1:0] cmt_list [8];
        cmt_list = '{8'h23, 8'hFF, CH_SPACE, CH_DQUOTE, 8'h00, CH_TAB, CH_SQUOTE,
                     CHAR_W'($urandom_range(255, 1))};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // comment char at its reset value (disabled)
        send_str("aZ9$_(");
        send_str("\"q'\"");
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(8'h80);
        pending_chars.push_back(8'h7F);
        pending_chars.push_back(8'h01);
        send_str("x\" ");
        pending_chars.push_back(CH_NUL);
        pending_chars.push_back(CH_NUL);
        send_str("\tk");
        pending_chars.push_back(CH_NUL);
        drain();

        set_comment(8'h23);
        send_str("a#b");
        pending_chars.push_back(CH_NUL);
        send_str("'#'");
        pending_chars.push_back(CH_NUL);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_comment(cmt_list[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 76; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 76; end
                default: begin send_idle = 34; recv_idle = 34; end
            endcase
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                queue_line(n);
                added += n;
            end
            drain();
        end

        send_idle = 0;
        recv_idle = 0;
        repeat (8) @(posedge clk);
        if (fail_count == 0 && tokens_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- line_tokenizer.f -----
design/ltok_pkg.sv
design/ltok_lexer.sv
design/ltok_result_queue.sv
design/line_tokenizer.sv
dv/testbench.sv
